/* hw/rtl/sofa_pkg.sv */
package sofa_pkg;

    localparam int DATA_W        = 32;
    localparam int KEY_W         = DATA_W + 1;
    localparam int MAX_ITEMS_DEF = 16;

    typedef enum logic {
        ST_LOAD,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;   // insert s_value (or mark dropped when full)
        logic shift;  // advance the chain toward the head
        logic clear;  // end of set: empty the chain, drop the overflow mark
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic empty;
        logic one_left;
    } dp_sts_t;

    // Ordering key: odd values first, then signed ascending. Compared unsigned.
    function automatic logic [KEY_W-1:0] sort_key(input logic [DATA_W-1:0] v);
        sort_key = {~v[0], ~v[DATA_W-1], v[DATA_W-2:0]};
    endfunction

endpackage

/* hw/rtl/sofa_datapath.sv */
module sofa_datapath #(
    parameter int MAX_ITEMS = sofa_pkg::MAX_ITEMS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  sofa_pkg::dp_cmd_t             cmd,
    input  logic signed [sofa_pkg::DATA_W-1:0] value,
    output sofa_pkg::dp_sts_t             sts,
    output logic signed [sofa_pkg::DATA_W-1:0] head_value,
    output logic                          overflow
);
    import sofa_pkg::*;

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    logic [DATA_W-1:0] cell_reg  [MAX_ITEMS];
    logic [DATA_W-1:0] cell_next [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] keep;
    logic [CNT_W-1:0] count_reg, count_next;
    logic dropped_reg, dropped_next;
    logic full;
    logic [KEY_W-1:0] new_key;

    assign full    = (count_reg == CNT_W'(MAX_ITEMS));
    assign new_key = sort_key(value);

    // Each occupied cell whose key does not exceed the new key keeps its entry
    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            keep[i] = (CNT_W'(i) < count_reg) && (sort_key(cell_reg[i]) <= new_key);
        end
    end

    // Insert into the chain or advance it toward the head
    always_comb begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            cell_next[i] = cell_reg[i];
            if (cmd.shift) begin
                if (i < MAX_ITEMS - 1) begin
                    cell_next[i] = cell_reg[i+1];
                end
            end else if (cmd.load && !full && !keep[i]) begin
                if (i == 0) begin
                    cell_next[i] = value;
                end else if (keep[i-1]) begin
                    cell_next[i] = value;
                end else begin
                    cell_next[i] = cell_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_ITEMS; i++) begin
            cell_reg[i] <= cell_next[i];
        end
    end

    // Track fill level and dropped items
    always_comb begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (cmd.clear) begin
            count_next   = '0;
            dropped_next = 1'b0;
        end else if (cmd.shift) begin
            count_next = count_reg - CNT_W'(1);
        end else if (cmd.load) begin
            if (full) begin
                dropped_next = 1'b1;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    assign sts.empty    = (count_reg == '0);
    assign sts.one_left = (count_reg == CNT_W'(1));
    assign head_value   = cell_reg[0];
    assign overflow     = dropped_reg;

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_ITEMS))
        else $error("fill count beyond capacity");

    a_head_ordered: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= CNT_W'(2)) |-> (sort_key(cell_reg[0]) <= sort_key(cell_reg[1])))
        else $error("chain head out of order");

    a_no_drop_below_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (!dropped_reg && cmd.load && !cmd.clear && !full) |=> !dropped_reg)
        else $error("overflow set without a full chain");

endmodule

/* hw/rtl/sofa_ctrl.sv */
module sofa_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_last_in,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_last_out,
    input  sofa_pkg::dp_sts_t sts,
    output sofa_pkg::dp_cmd_t cmd
);
    import sofa_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    // Load until the closing transaction, then drain the chain
    always_comb begin
        state_next = state_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        m_last_out = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            ST_LOAD: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid && s_last_in) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                m_valid    = 1'b1;
                m_last_out = sts.one_left;
                if (m_ready) begin
                    cmd.shift = 1'b1;
                    if (sts.one_left) begin
                        cmd.clear  = 1'b1;
                        state_next = ST_LOAD;
                    end
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    a_emit_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !sts.empty)
        else $error("emitting from an empty chain");

    a_sides_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("load and emit overlap");

    a_back_to_load: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_out) |=> (s_ready && sts.empty))
        else $error("set not cleared after final result");

endmodule

/* hw/rtl/sort_odd_first_ascending.sv */
// Collects a set of signed 32-bit values, one per input transaction, into an
// insertion chain of MAX_ITEMS compare cells kept in order as odd values
// ascending followed by even values ascending. The transaction with s_last_in
// closes the set, and the block then emits every stored element from the
// chain head, one per cycle while m_ready is high, with m_last_out on the
// final one. No input is taken while a set is draining. Elements beyond
// MAX_ITEMS are dropped and every result of that set carries m_overflow.
// The chain is empty after reset.
module sort_odd_first_ascending #(
    parameter int MAX_ITEMS = sofa_pkg::MAX_ITEMS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [sofa_pkg::DATA_W-1:0] s_value,
    input  logic                               s_last_in,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [sofa_pkg::DATA_W-1:0] m_sorted_value,
    output logic                               m_last_out,
    output logic                               m_overflow
);
    import sofa_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    sofa_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_last_in  (s_last_in),
        .s_ready    (s_ready),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_last_out (m_last_out),
        .sts        (sts),
        .cmd        (cmd)
    );

    sofa_datapath #(
        .MAX_ITEMS (MAX_ITEMS)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .value      (s_value),
        .sts        (sts),
        .head_value (m_sorted_value),
        .overflow   (m_overflow)
    );

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
    import sofa_pkg::*;

    localparam int SET_CAPACITY = sofa_pkg::MAX_ITEMS_DEF;
    localparam int RANDOM_ITEMS = 320;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 200000;

    localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    typedef enum int {
        VAL_FULL_RANGE,
        VAL_NARROW,
        VAL_EXTREME,
        VAL_FORCED_PARITY
    } value_style_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
        logic                     overflow;
    } sorted_result_t;

    logic                     aclk;
    logic                     aresetn   = 1'b0;
    logic                     s_valid   = 1'b0;
    logic                     s_ready;
    logic signed [DATA_W-1:0] s_value   = '0;
    logic                     s_last_in = 1'b0;
    logic                     m_valid;
    logic                     m_ready   = 1'b0;
    logic signed [DATA_W-1:0] m_sorted_value;
    logic                     m_last_out;
    logic                     m_overflow;

    // Predictor state: the set being loaded and its overflow mark
    logic signed [DATA_W-1:0] loaded_set[$];
    bit                       set_dropped;
    sorted_result_t           expected_order[$];

    int error_count = 0;
    int cycle_count = 0;
    int burst_left  = 0;
    int random_items;

    int stall_mode      = 0;
    int stall_mode_left = 0;
    int stall_run_left  = 0;

    sort_odd_first_ascending #(
        .MAX_ITEMS(SET_CAPACITY)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_value       (s_value),
        .s_last_in     (s_last_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sorted_value(m_sorted_value),
        .m_last_out    (m_last_out),
        .m_overflow    (m_overflow)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Bound the run
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Odd values first, then signed ascending within each parity group
    function automatic bit goes_ahead(logic signed [DATA_W-1:0] a, logic signed [DATA_W-1:0] b);
        if (a[0] != b[0])
            return a[0];
        return a < b;
    endfunction

    // Store one accepted element; on the closing element queue the whole set in output order
    function automatic void fold_element(logic signed [DATA_W-1:0] v, logic last);
        logic signed [DATA_W-1:0] ordered[$];
        sorted_result_t           r;
        int                       j;
        if (loaded_set.size() < SET_CAPACITY)
            loaded_set.push_back(v);
        else
            set_dropped = 1'b1;
        if (!last)
            return;
        foreach (loaded_set[i]) begin
            j = ordered.size();
            while (j > 0 && goes_ahead(loaded_set[i], ordered[j-1]))
                j--;
            ordered.insert(j, loaded_set[i]);
        end
        foreach (ordered[i]) begin
            r.value    = ordered[i];
            r.last     = (i == ordered.size() - 1);
            r.overflow = set_dropped;
            expected_order.push_back(r);
        end
        loaded_set.delete();
        set_dropped = 1'b0;
    endfunction

    // Send one transaction, idling between bursts
    task automatic send_element(input logic signed [DATA_W-1:0] v, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_valid <= 1'b0;
                s_value <= $urandom;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_valid   <= 1'b1;
        s_value   <= v;
        s_last_in <= last;
        do
            @(posedge aclk);
        while (!s_ready);
        fold_element(v, last);
        burst_left--;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value(value_style_t style);
        logic signed [DATA_W-1:0] v;
        case (style)
            VAL_FULL_RANGE: v = $urandom;
            VAL_NARROW:     v = $signed($urandom_range(0, 12)) - 6;
            VAL_EXTREME: begin
                case ($urandom_range(0, 5))
                    0: v = INT_MIN;
                    1: v = INT_MAX;
                    2: v = INT_MIN + 1;
                    3: v = INT_MAX - 1;
                    4: v = -1;
                    default: v = 0;
                endcase
            end
            default: begin
                v    = $urandom;
                v[0] = 1'($urandom_range(0, 1));
            end
        endcase
        return v;
    endfunction

    // Extremes of the range, both parities, duplicates
    task automatic test_extremes();
        send_element(INT_MIN, 1'b0);
        send_element(INT_MAX, 1'b0);
        send_element(-1, 1'b0);
        send_element(0, 1'b0);
        send_element(1, 1'b0);
        send_element(-2, 1'b0);
        send_element(7, 1'b0);
        send_element(7, 1'b0);
        send_element(INT_MIN, 1'b1);
    endtask

    // One-element sets, odd then even
    task automatic test_single_element();
        send_element(-3, 1'b1);
        send_element(INT_MIN, 1'b1);
    endtask

    // Fill the store, then close the set with an element that gets dropped
    task automatic test_overflow();
        for (int i = 0; i < SET_CAPACITY; i++)
            send_element(pick_value(VAL_FULL_RANGE), 1'b0);
        send_element(pick_value(VAL_FULL_RANGE), 1'b1);
    endtask

    // Random sets, mostly within capacity, some exactly full, some overflowing
    task automatic test_random_sets();
        int           set_size;
        int           roll;
        value_style_t style;
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                set_size = 1;
            else if (roll < 70)
                set_size = $urandom_range(2, SET_CAPACITY - 1);
            else if (roll < 82)
                set_size = SET_CAPACITY;
            else
                set_size = $urandom_range(SET_CAPACITY + 1, SET_CAPACITY + 6);
            style = value_style_t'($urandom_range(0, 3));
            for (int i = 0; i < set_size; i++) begin
                send_element(pick_value(($urandom_range(0, 4) == 0) ?
                                        value_style_t'($urandom_range(0, 3)) : style),
                             i == set_size - 1);
                random_items++;
            end
        end
    endtask

    // Stall the result channel: always ready, coin flips, or long runs
    always @(posedge aclk) begin
        if (stall_mode_left == 0) begin
            stall_mode      <= $urandom_range(0, 2);
            stall_mode_left <= $urandom_range(20, 200);
        end else begin
            stall_mode_left <= stall_mode_left - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= 1'($urandom_range(0, 1));
            default: begin
                if (stall_run_left == 0) begin
                    m_ready        <= ~m_ready;
                    stall_run_left <= m_ready ? $urandom_range(1, 8) : $urandom_range(1, 6);
                end else begin
                    stall_run_left <= stall_run_left - 1;
                end
            end
        endcase
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        sorted_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_order.size() == 0) begin
                $error("unexpected result: sorted_value=%0d last_out=%0b overflow=%0b",
                       m_sorted_value, m_last_out, m_overflow);
                error_count++;
            end else begin
                want = expected_order.pop_front();
                if (m_sorted_value !== want.value) begin
                    $error("sorted_value: expected %0d, got %0d", want.value, m_sorted_value);
                    error_count++;
                end
                if (m_last_out !== want.last) begin
                    $error("last_out: expected %0b, got %0b", want.last, m_last_out);
                    error_count++;
                end
                if (m_overflow !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b", want.overflow, m_overflow);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_extremes();
        test_single_element();
        test_overflow();
        test_random_sets();

        // Drain outstanding results, then watch for strays
        s_valid <= 1'b0;
        while (expected_order.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && expected_order.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
